/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/hz_pkg.sv */
// shared types and constants of the hazard issue timer
package hz_pkg;

    localparam int TAG_W           = 8;
    localparam int HIST_DEPTH      = 5;
    localparam int DELAY_WIDTH_DEF = 12;
    localparam int ISSUE_W         = 12;
    localparam int TOTAL_W         = 13;
    localparam int ISSUE_MAX       = 4095;
    localparam int STAGES          = 6;
    localparam int QDEPTH          = 2;

    // classified request passed from front to back
    typedef struct packed {
        logic                  start;
        logic [HIST_DEPTH-1:0] hits;   // bit k = match at distance k+1
    } t_hz_req;

endpackage

/* rtl/core/hz_if.sv */
// request and result channel interfaces
interface hz_in_if;
    import hz_pkg::*;

    logic             valid;
    logic             ready;
    logic             start_of_program;
    logic [TAG_W-1:0] dest_reg;
    logic [TAG_W-1:0] src_a_reg;
    logic [TAG_W-1:0] src_b_reg;

    modport source (output valid, output start_of_program, output dest_reg,
                    output src_a_reg, output src_b_reg, input ready);
    modport sink   (input valid, input start_of_program, input dest_reg,
                    input src_a_reg, input src_b_reg, output ready);
endinterface

interface hz_out_if;
    import hz_pkg::*;

    logic               valid;
    logic               ready;
    logic [ISSUE_W-1:0] issue_cycle;
    logic [TOTAL_W-1:0] total_cycles;

    modport source (output valid, output issue_cycle, output total_cycles, input ready);
    modport sink   (input valid, input issue_cycle, input total_cycles, output ready);
endinterface

/* rtl/core/hz_front.sv */
// front end: destination history and hazard classification
module hz_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hz_in_if.sink           i_in,
    output hz_pkg::t_hz_req o_req,
    output logic            o_req_valid,
    input  logic            i_req_ready
);
    import hz_pkg::*;

    logic [TAG_W-1:0]      r_dests [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] r_valid;
    logic [HIST_DEPTH-1:0] w_hits;
    logic                  w_accept;

    assign i_in.ready  = i_req_ready;
    assign o_req_valid = i_in.valid;
    assign w_accept    = i_in.valid & i_req_ready;

    always_comb begin
        for (int k = 0; k < HIST_DEPTH; k++) begin
            w_hits[k] = r_valid[k] & ((r_dests[k] == i_in.src_a_reg) |
                                      (r_dests[k] == i_in.src_b_reg));
        end
    end

    assign o_req.start = i_in.start_of_program;
    assign o_req.hits  = w_hits;

    // valid bits: start of program keeps only the new entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_accept) begin
            if (i_in.start_of_program) begin
                r_valid <= HIST_DEPTH'(1);
            end else begin
                r_valid <= {r_valid[HIST_DEPTH-2:0], 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dests[0] <= i_in.dest_reg;
            for (int k = 1; k < HIST_DEPTH; k++) begin
                r_dests[k] <= r_dests[k-1];
            end
        end
    end

endmodule

/* rtl/core/hz_queue.sv */
// short fifo between front and back
`include "assert_macros.svh"
module hz_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hz_pkg::t_hz_req i_push_data,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    output hz_pkg::t_hz_req o_pop_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready
);
    import hz_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_hz_req         r_mem [QDEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wptr;
    logic [PW-1:0]   n_rptr;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_count != CW'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign w_push       = i_push_valid & o_push_ready;
    assign w_pop        = o_pop_valid & i_pop_ready;

    assign n_wptr = (r_wptr == PW'(QDEPTH - 1)) ? '0 : r_wptr + PW'(1);
    assign n_rptr = (r_rptr == PW'(QDEPTH - 1)) ? '0 : r_rptr + PW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= n_wptr;
            end
            if (w_pop) begin
                r_rptr <= n_rptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(QDEPTH))
    `ASSERT_NEXT(a_count_step, i_clk, i_rst_n, 1'b1, (r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1)) || (r_count == $past(r_count) - CW'(1)))

endmodule

/* rtl/core/hz_back.sv */
// back end: stall rules, running delay and result register
`include "assert_macros.svh"
module hz_back #(
    parameter int DELAY_WIDTH = hz_pkg::DELAY_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_mode,
    input  hz_pkg::t_hz_req i_req,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    hz_out_if.source        o_out
);
    import hz_pkg::*;

    localparam int CW = (DELAY_WIDTH > ISSUE_W) ? DELAY_WIDTH : ISSUE_W;

    logic [HIST_DEPTH-1:0]  r_flags;
    logic                   r_parity;
    logic [DELAY_WIDTH-1:0] r_delay;
    logic                   r_out_valid;
    logic [ISSUE_W-1:0]     r_issue;
    logic [TOTAL_W-1:0]     r_total;

    logic [HIST_DEPTH-1:0]  n_flags;
    logic                   n_parity;
    logic [DELAY_WIDTH-1:0] n_delay;
    logic [ISSUE_W-1:0]     n_issue;
    logic [1:0]             w_dep;
    logic                   w_p;
    logic [1:0]             w_inc;
    logic [DELAY_WIDTH:0]   w_sum;
    logic [CW-1:0]          w_delay_ext;
    logic [HIST_DEPTH-1:0]  w_h;
    logic                   w_pop;

    assign o_req_ready = !r_out_valid || o_out.ready;
    assign w_pop       = i_req_valid && o_req_ready;
    assign w_h         = i_req.hits;

    always_comb begin
        n_flags  = r_flags;
        n_parity = r_parity;
        w_dep    = 2'd0;
        w_p      = 1'b0;
        w_inc    = 2'd0;
        if (i_mode) begin
            // superscalar rule, distance 5 down to 1
            w_p = ~r_parity;
            if (w_h[4]) begin
                w_p = 1'b1;
            end
            n_flags[4] = w_h[4] & ~|r_flags[4:0];
            n_flags[3] = w_h[3] & ~|r_flags[3:0];
            if (n_flags[3]) begin
                w_dep = {1'b0, w_p};
            end
            n_flags[2] = w_h[2] & ~|r_flags[2:0];
            if (n_flags[2]) begin
                w_dep = 2'd1;
            end
            n_flags[1] = w_h[1] & ~|r_flags[1:0];
            if (n_flags[1]) begin
                w_dep = 2'd1 + {1'b0, w_p};
            end
            n_flags[0] = w_h[0];
            if (w_h[0]) begin
                w_dep = 2'd2;
                w_p   = 1'b1;
            end
            n_parity = w_p;
            w_inc    = w_dep + {1'b0, w_p};
        end else begin
            // pipelined rule, single overlap flag
            if (w_h[1]) begin
                n_flags[0] = ~r_flags[0];
                w_dep      = {1'b0, ~r_flags[0]};
            end else begin
                n_flags[0] = 1'b0;
            end
            if (w_h[0]) begin
                w_dep      = 2'd2;
                n_flags[0] = 1'b1;
            end
            w_inc = w_dep + 2'd1;
        end
        w_sum   = {1'b0, r_delay} + (DELAY_WIDTH+1)'(w_inc);
        n_delay = w_sum[DELAY_WIDTH] ? '1 : w_sum[DELAY_WIDTH-1:0];
        if (i_req.start) begin
            n_flags  = '0;
            n_parity = 1'b1;
            n_delay  = '0;
        end
    end

    assign w_delay_ext = CW'(n_delay);
    assign n_issue     = (w_delay_ext > CW'(ISSUE_MAX)) ? ISSUE_W'(ISSUE_MAX)
                                                       : ISSUE_W'(w_delay_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_parity    <= 1'b1;
            r_delay     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_flags     <= n_flags;
                r_parity    <= n_parity;
                r_delay     <= n_delay;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_issue <= n_issue;
            r_total <= TOTAL_W'(n_issue) + TOTAL_W'(STAGES);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.issue_cycle  = r_issue;
    assign o_out.total_cycles = r_total;

    `ASSERT_NEXT(a_start_clears, i_clk, i_rst_n, w_pop && i_req.start,
                 r_parity && (r_flags == '0) && (r_delay == '0))
    `ASSERT_NEXT(a_delay_grows, i_clk, i_rst_n, w_pop && !i_req.start, r_delay >= $past(r_delay))

endmodule

/* rtl/core/pipeline_hazard_issue_timer.sv */
// top level of the pipeline hazard issue timer
// Times instructions through a six-stage pipeline. Each request carries a
// destination tag, two source tags and a start-of-program mark; each result
// gives the instruction's issue cycle (saturating at 4095) and the total cycle
// count, issue cycle plus six. The front end holds the last five destinations
// and compares both sources against them combinationally; the back end applies
// the pipelined or superscalar stall rule selected by i_cfg_wdata and keeps
// the overlap flags, parity and running delay. A two-entry queue sits between
// them and a result register sits at the output, so a new request is taken
// every cycle while results drain: one instruction per cycle sustained. An
// accepted request passes through the queue entry, then the rule update into
// the result register. The user must write the mode register only while the
// block is idle; the block does not enforce it. DELAY_WIDTH sets the running
// delay width, which saturates at its all-ones value. Reset is synchronous.
module pipeline_hazard_issue_timer #(
    parameter int DELAY_WIDTH = hz_pkg::DELAY_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    hz_in_if.sink    i_in,
    hz_out_if.source o_out,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata
);
    import hz_pkg::*;

    // superscalar_mode register
    logic    r_mode;

    // classified request between front and queue
    t_hz_req w_front_req;
    logic    w_front_valid;
    logic    w_front_ready;

    // queue head toward the back end
    t_hz_req w_back_req;
    logic    w_back_valid;
    logic    w_back_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // history and tag compares
    hz_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_req       (w_front_req),
        .o_req_valid (w_front_valid),
        .i_req_ready (w_front_ready)
    );

    // decouples the compare stage from the rule stage
    hz_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_data  (w_front_req),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .o_pop_data   (w_back_req),
        .o_pop_valid  (w_back_valid),
        .i_pop_ready  (w_back_ready)
    );

    // stall rules, delay accumulation and result register
    hz_back #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_req       (w_back_req),
        .i_req_valid (w_back_valid),
        .o_req_ready (w_back_ready),
        .o_out       (o_out)
    );

endmodule

/* sim/tb_pipeline_hazard_issue_timer.sv */
// self-checking testbench of the pipeline hazard issue timer with its own timing predictor
import hz_pkg::*;

localparam int unsigned TIMER_DELAY_MAX = (1 << DELAY_WIDTH_DEF) - 1;

typedef struct packed {
    logic [ISSUE_W-1:0] issue_cycle;
    logic [TOTAL_W-1:0] total_cycles;
} t_issue_timing;

// predicts the timing of each accepted request and checks the results in order
class t_issue_timing_book;
    bit                 superscalar;
    bit [TAG_W-1:0]     dests [HIST_DEPTH];
    bit                 dests_valid [HIST_DEPTH];
    bit                 overlap [HIST_DEPTH];
    bit                 parity;
    int unsigned        delay;
    t_issue_timing      timings_q [$];
    int                 errors;

    function new();
        superscalar = 1'b0;
        errors      = 0;
        clear_program();
    endfunction

    function void clear_program();
        for (int k = 0; k < HIST_DEPTH; k++) begin
            dests[k]       = '0;
            dests_valid[k] = 1'b0;
            overlap[k]     = 1'b0;
        end
        parity = 1'b1;
        delay  = 0;
    endfunction

    // source match against the destination at the given distance
    function bit hit(int distance, bit [TAG_W-1:0] src_a, bit [TAG_W-1:0] src_b);
        return dests_valid[distance-1] &&
               (dests[distance-1] == src_a || dests[distance-1] == src_b);
    endfunction

    function bit flags_clear(int distance);
        for (int k = 0; k < distance; k++)
            if (overlap[k])
                return 1'b0;
        return 1'b1;
    endfunction

    function void note_request(bit start, bit [TAG_W-1:0] dest,
                               bit [TAG_W-1:0] src_a, bit [TAG_W-1:0] src_b);
        int unsigned   dep;
        int unsigned   p;
        int unsigned   issue;
        t_issue_timing timing;
        dep = 0;
        p   = 0;
        if (start) begin
            clear_program();
        end else if (superscalar) begin
            p = parity ? 0 : 1;
            if (hit(5, src_a, src_b)) begin
                p          = 1;
                overlap[4] = flags_clear(5);
            end else begin
                overlap[4] = 1'b0;
            end
            if (hit(4, src_a, src_b) && flags_clear(4)) begin
                overlap[3] = 1'b1;
                dep        = p;
            end else begin
                overlap[3] = 1'b0;
            end
            if (hit(3, src_a, src_b) && flags_clear(3)) begin
                overlap[2] = 1'b1;
                dep        = 1;
            end else begin
                overlap[2] = 1'b0;
            end
            if (hit(2, src_a, src_b) && flags_clear(2)) begin
                overlap[1] = 1'b1;
                dep        = 1 + p;
            end else begin
                overlap[1] = 1'b0;
            end
            if (hit(1, src_a, src_b)) begin
                dep        = 2;
                overlap[0] = 1'b1;
                p          = 1;
            end else begin
                overlap[0] = 1'b0;
            end
            parity = (p != 0);
            delay  = delay + dep + p;
        end else begin
            if (hit(2, src_a, src_b)) begin
                dep        = overlap[0] ? 0 : 1;
                overlap[0] = !overlap[0];
            end else begin
                overlap[0] = 1'b0;
            end
            if (hit(1, src_a, src_b)) begin
                dep        = 2;
                overlap[0] = 1'b1;
            end
            delay = delay + dep + 1;
        end
        if (delay > TIMER_DELAY_MAX)
            delay = TIMER_DELAY_MAX;

        for (int k = HIST_DEPTH - 1; k > 0; k--) begin
            dests[k]       = dests[k-1];
            dests_valid[k] = dests_valid[k-1];
        end
        dests[0]       = dest;
        dests_valid[0] = 1'b1;

        issue               = (delay > ISSUE_MAX) ? ISSUE_MAX : delay;
        timing.issue_cycle  = issue[ISSUE_W-1:0];
        timing.total_cycles = TOTAL_W'(issue + STAGES);
        timings_q.push_back(timing);
    endfunction

    function void check_result(logic [ISSUE_W-1:0] issue_cycle,
                               logic [TOTAL_W-1:0] total_cycles);
        t_issue_timing exp_timing;
        if (timings_q.size() == 0) begin
            errors++;
            $error("result with no request pending: issue_cycle %0d total_cycles %0d",
                   issue_cycle, total_cycles);
            return;
        end
        exp_timing = timings_q.pop_front();
        if (issue_cycle !== exp_timing.issue_cycle) begin
            errors++;
            $error("issue_cycle mismatch: expected %0d, actual %0d",
                   exp_timing.issue_cycle, issue_cycle);
        end
        if (total_cycles !== exp_timing.total_cycles) begin
            errors++;
            $error("total_cycles mismatch: expected %0d, actual %0d",
                   exp_timing.total_cycles, total_cycles);
        end
    endfunction

    function int pending();
        return timings_q.size();
    endfunction
endclass

module tb_pipeline_hazard_issue_timer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 40;
    localparam int SAT_ITEMS   = 1700;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cfg_we    = 1'b0;
    logic cfg_wdata = 1'b0;
    logic rx_ready  = 1'b0;

    // idle enables per phase, both sides
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int unsigned rx_hold = 0;

    // destinations as sent, newest first, used to aim sources at live hazards
    bit [TAG_W-1:0] sent_dests [HIST_DEPTH];
    // small per-program tag pool so that sources hit recent destinations often
    bit [TAG_W-1:0] tag_pool [8];

    t_issue_timing_book book = new();

    hz_in_if  req_if ();
    hz_out_if res_if ();

    assign res_if.ready = rx_ready;

    pipeline_hazard_issue_timer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (req_if),
        .o_out       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // mostly no gap, often a short one, now and then a long one
    function automatic int unsigned idle_len(bit enabled);
        int unsigned r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side: check every accepted result, then pick the next ready value
    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready)
            book.check_result(res_if.issue_cycle, res_if.total_cycles);
        if (rx_hold != 0) begin
            rx_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            rx_ready <= 1'b1;
            rx_hold = idle_len(rx_idle_en);
        end
    end

    // one request, held until the block takes it; valid stays high for a back-to-back request
    task automatic send_request(bit start, bit [TAG_W-1:0] dest,
                                bit [TAG_W-1:0] src_a, bit [TAG_W-1:0] src_b);
        int unsigned gap;
        gap = idle_len(tx_idle_en);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid            <= 1'b1;
        req_if.start_of_program <= start;
        req_if.dest_reg         <= dest;
        req_if.src_a_reg        <= src_a;
        req_if.src_b_reg        <= src_b;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        book.note_request(start, dest, src_a, src_b);
        for (int k = HIST_DEPTH - 1; k > 0; k--)
            sent_dests[k] = sent_dests[k-1];
        sent_dests[0] = dest;
    endtask

    // stop sending and wait for every predicted result; sampled at the falling
    // edge so the count never races the result checker
    task automatic drain_requests();
        req_if.valid <= 1'b0;
        while (book.pending() != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // mode register is only touched with the block idle
    task automatic write_mode(bit mode);
        drain_requests();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        book.superscalar = mode;
    endtask

    function automatic bit [TAG_W-1:0] pick_src();
        case ($urandom_range(0, 3))
            0, 1:    return sent_dests[3'($urandom_range(0, HIST_DEPTH - 1))];
            2:       return tag_pool[3'($urandom_range(0, 7))];
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // a well-formed program item most of the time, an odd one now and then
    task automatic send_program_item(bit first);
        bit [TAG_W-1:0] dest;
        bit [TAG_W-1:0] src_a;
        bit [TAG_W-1:0] src_b;
        if ($urandom_range(0, 15) == 0) begin
            // noise: stray start marks and unrelated tags
            send_request($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else begin
            dest  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                 : tag_pool[3'($urandom_range(0, 7))];
            src_a = pick_src();
            src_b = pick_src();
            send_request(first, dest, src_a, src_b);
        end
    endtask

    initial begin : stimulus
        int  sent;
        int  plen;
        bit  paused;
        req_if.valid            <= 1'b0;
        req_if.start_of_program <= 1'b0;
        req_if.dest_reg         <= '0;
        req_if.src_a_reg        <= '0;
        req_if.src_b_reg        <= '0;
        for (int k = 0; k < HIST_DEPTH; k++)
            sent_dests[k] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pipelined rule, directed
        write_mode(1'b0);
        // no start mark after reset: zero tags must not match the empty history
        send_request(1'b0, 8'h00, 8'h00, 8'h00);
        send_request(1'b1, 8'hff, 8'hff, 8'hff);
        send_request(1'b0, 8'h01, 8'hff, 8'h00);   // distance 1
        send_request(1'b0, 8'h02, 8'hff, 8'h80);   // distance 2 with overlap flag set
        send_request(1'b0, 8'h03, 8'h01, 8'h01);   // distance 2 with flag clear
        send_request(1'b0, 8'h04, 8'h55, 8'h02);   // distance 2 again, flag now set
        send_request(1'b0, 8'h05, 8'h04, 8'h03);   // distances 1 and 2 together
        send_request(1'b0, 8'haa, 8'h10, 8'h20);   // no hazard
        send_request(1'b0, 8'h55, 8'h01, 8'h02);   // only far distances, ignored here

        // superscalar rule, directed, continuing without a start first
        write_mode(1'b1);
        send_request(1'b0, 8'h80, 8'h55, 8'haa);
        send_request(1'b1, 8'h10, 8'h00, 8'h00);
        send_request(1'b0, 8'h11, 8'h77, 8'h66);
        send_request(1'b0, 8'h12, 8'h77, 8'h66);
        send_request(1'b0, 8'h13, 8'h77, 8'h66);
        send_request(1'b0, 8'h14, 8'h77, 8'h66);
        send_request(1'b0, 8'h20, 8'h10, 8'hee);   // distance 5, flags clear
        send_request(1'b0, 8'h21, 8'h12, 8'hee);   // distance 4, flags clear
        send_request(1'b0, 8'h22, 8'h13, 8'h13);   // distance 4 blocked by flag
        send_request(1'b0, 8'h23, 8'h14, 8'hf0);   // distance 4, flags clear again
        send_request(1'b0, 8'h24, 8'h21, 8'h00);   // distance 3
        send_request(1'b0, 8'h25, 8'h24, 8'h23);   // distances 1 and 2
        send_request(1'b0, 8'h26, 8'h23, 8'h22);   // distances 3 and 4
        send_request(1'b0, 8'h27, 8'h22, 8'h21);   // distance 5

        // random programs, mode and idling change per phase
        for (int phase = 0; phase < PHASES; phase++) begin
            write_mode(phase == 0 ? 1'b1 : phase == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
            tx_idle_en = (phase % 4 != 3) && (phase % 4 != 1);
            rx_idle_en = (phase % 4 != 3);
            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS) begin
                plen = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120)
                                                   : $urandom_range(1, 40);
                for (int k = 0; k < 8; k++)
                    tag_pool[k] = 8'($urandom_range(0, 255));
                // most programs open with a start mark, some run on from the last
                for (int i = 0; i < plen; i++) begin
                    send_program_item(i == 0 && $urandom_range(0, 9) != 0);
                    sent++;
                end
                // once in phase 2, halfway through, the sender holds off until the block has returned every result
                if (phase == 2 && !paused && sent >= PHASE_ITEMS / 2) begin
                    drain_requests();
                    paused = 1'b1;
                end
            end
        end

        // one long program of back-to-back hazards drives the delay into saturation
        write_mode(1'($urandom_range(0, 1)));
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_request(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        for (int i = 0; i < SAT_ITEMS; i++)
            send_request(1'b0, 8'($urandom_range(0, 255)),
                         ($urandom_range(0, 7) != 0) ? sent_dests[0]
                                                     : 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
        // start mark out of the saturated state
        send_request(1'b1, 8'h00, 8'hff, 8'h00);
        send_request(1'b0, 8'hff, 8'h00, 8'hff);

        drain_requests();
        repeat (8) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0) begin
            $display("pipeline_hazard_issue_timer test passed");
        end else begin
            $display("pipeline_hazard_issue_timer test failed");
        end
        $finish;
    end

    // generous limit, far above the slowest correct run
    initial begin
        #12_000_000;
        $display("pipeline_hazard_issue_timer test failed");
        $finish;
    end
endmodule
